// ===== src/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and helpers shared by the pulse-width frame encoder.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int TIME_W = 10;
    localparam int DUR_W  = 18;
    localparam int CRC_W  = 16;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CRC_W-1:0] CRC_POLY      = 16'h8408;
    localparam logic [CRC_W-1:0] CRC_SEED_RST  = 16'h3791;
    localparam logic [TIME_W-1:0] OFF_RST      = 10'd170;
    localparam logic [TIME_W-1:0] ON_ZERO_RST  = 10'd240;
    localparam logic [TIME_W-1:0] ON_ONE_RST   = 10'd360;
    localparam logic [TIME_W-1:0] START_HI_RST = 10'd480;
    localparam logic [TIME_W-1:0] END_HI_RST   = 10'd570;
    localparam logic [DUR_W-1:0] US_PER_MS     = 18'd1000;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_OFF_TIME   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ON_ZERO    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ON_ONE     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_START_HIGH = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_END_HIGH   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_CRC_ENABLE = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_CRC_SEED   = 3'd6;

    typedef struct packed {
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] on_time_zero;
        logic [TIME_W-1:0] on_time_one;
        logic [TIME_W-1:0] start_high_time;
        logic [TIME_W-1:0] end_high_time;
        logic              crc_enable;
        logic [CRC_W-1:0]  crc_seed;
    } cfg_t;

    // one classified byte handed from front to back
    typedef struct packed {
        logic [7:0]       data;
        logic             start;
        logic             last;
        logic [CRC_W-1:0] crc;
        logic [DUR_W-1:0] recharge_us;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_CRC,
        PH_END
    } phase_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] byte_in);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'd0, byte_in};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // bit phases are one short; zero stays zero
    function automatic logic [TIME_W-1:0] minus_one(input logic [TIME_W-1:0] v);
        return (v == '0) ? '0 : v - 1'b1;
    endfunction

endpackage

// ===== src/pfe_front.sv =====
// ----------------------------------------------------------------------------
// pfe_front
// Accepts payload words, tracks the open frame and runs the CRC per byte.
// ----------------------------------------------------------------------------
module pfe_front
    import pfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       in_first,
    input  logic       in_last,
    input  logic [7:0] in_recharge,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic             open_reg;
    logic             start;
    logic [CRC_W-1:0] crc_base;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // a byte outside an open frame opens one
    assign start    = in_first || !open_reg;
    assign crc_base = start ? cfg.crc_seed : crc_reg;
    assign crc_next = crc_byte(crc_base, in_data);

    always_comb
    begin
        q_cmd.data        = in_data;
        q_cmd.start       = start;
        q_cmd.last        = in_last;
        q_cmd.crc         = crc_next;
        q_cmd.recharge_us = DUR_W'({10'd0, in_recharge} * US_PER_MS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_SEED_RST;
            open_reg <= 1'b0;
        end
        else if (q_push)
        begin
            crc_reg  <= crc_next;
            open_reg <= !in_last;
        end
    end

endmodule

// ===== src/pfe_fifo.sv =====
// ----------------------------------------------------------------------------
// pfe_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module pfe_fifo
    import pfe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t rd_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/pfe_back.sv =====
// ----------------------------------------------------------------------------
// pfe_back
// Segment sequencer: expands one command into drive segments, one per cycle
// while out_ready does not stall it, into an output register.
// ----------------------------------------------------------------------------
module pfe_back
    import pfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_drive_on,
    output logic [DUR_W-1:0] out_duration,
    output logic             out_end_of_run,
    output logic             out_frame_done
);

    phase_t           ph_reg;
    phase_t           ph_next;
    logic [4:0]       cnt_reg;
    logic [4:0]       cnt_next;
    cmd_t             cmd_reg;
    logic             adv;
    logic             bit_val;
    logic             seg_lvl;
    logic [DUR_W-1:0] seg_dur;
    logic             seg_eor;
    logic             seg_done;
    logic [TIME_W-1:0] bit_on;

    logic             valid_reg;
    logic             lvl_reg;
    logic [DUR_W-1:0] dur_reg;
    logic             eor_reg;
    logic             done_reg;

    assign adv = (ph_reg != PH_IDLE) && (!valid_reg || out_ready);

    always_comb
    begin
        ph_next  = ph_reg;
        cnt_next = cnt_reg;
        q_pop    = 1'b0;
        seg_lvl  = cnt_reg[0];
        seg_dur  = '0;
        seg_eor  = 1'b0;
        seg_done = 1'b0;
        bit_val  = (ph_reg == PH_CRC) ? cmd_reg.crc[cnt_reg[4:1]]
                                      : cmd_reg.data[cnt_reg[3:1]];
        bit_on   = bit_val ? cfg.on_time_one : cfg.on_time_zero;
        case (ph_reg)
            PH_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    ph_next  = q_cmd.start ? PH_START : PH_DATA;
                    cnt_next = '0;
                end
            end
            PH_START:
            begin
                // S, 0, 1 each as off then on
                case (cnt_reg[2:0])
                    3'd1:    seg_dur = DUR_W'(cfg.start_high_time);
                    3'd3:    seg_dur = DUR_W'(cfg.on_time_zero);
                    3'd5:    seg_dur = DUR_W'(cfg.on_time_one);
                    default: seg_dur = DUR_W'(cfg.off_time);
                endcase
                if (adv)
                begin
                    cnt_next = (cnt_reg == 5'd5) ? '0 : cnt_reg + 1'b1;
                    ph_next  = (cnt_reg == 5'd5) ? PH_DATA : PH_START;
                end
            end
            PH_DATA,
            PH_CRC:
            begin
                seg_dur = cnt_reg[0] ? DUR_W'(minus_one(bit_on))
                                     : DUR_W'(minus_one(cfg.off_time));
                if ((ph_reg == PH_DATA) && (cnt_reg == 5'd15) && !cmd_reg.last)
                begin
                    seg_eor = 1'b1;
                end
                if (adv)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if ((ph_reg == PH_DATA) && (cnt_reg == 5'd15))
                    begin
                        cnt_next = '0;
                        if (!cmd_reg.last)
                        begin
                            ph_next = PH_IDLE;
                        end
                        else
                        begin
                            ph_next = cfg.crc_enable ? PH_CRC : PH_END;
                        end
                    end
                    else if ((ph_reg == PH_CRC) && (cnt_reg == 5'd31))
                    begin
                        cnt_next = '0;
                        ph_next  = PH_END;
                    end
                end
            end
            PH_END:
            begin
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        seg_lvl = 1'b0;
                        seg_dur = DUR_W'(cfg.off_time);
                    end
                    2'd1:
                    begin
                        seg_lvl = 1'b1;
                        seg_dur = DUR_W'(cfg.end_high_time);
                    end
                    2'd2:
                    begin
                        seg_lvl = 1'b1;
                        seg_dur = cmd_reg.recharge_us;
                    end
                    default:
                    begin
                        // level held until the next frame
                        seg_lvl  = 1'b0;
                        seg_dur  = '0;
                        seg_eor  = 1'b1;
                        seg_done = 1'b1;
                    end
                endcase
                if (adv)
                begin
                    cnt_next = (cnt_reg[1:0] == 2'd3) ? '0 : cnt_reg + 1'b1;
                    ph_next  = (cnt_reg[1:0] == 2'd3) ? PH_IDLE : PH_END;
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= PH_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ph_reg  <= ph_next;
            cnt_reg <= cnt_next;
            if (adv)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (adv)
        begin
            lvl_reg  <= seg_lvl;
            dur_reg  <= seg_dur;
            eor_reg  <= seg_eor;
            done_reg <= seg_done;
        end
    end

    assign out_valid      = valid_reg;
    assign out_drive_on   = lvl_reg;
    assign out_duration   = dur_reg;
    assign out_end_of_run = eor_reg;
    assign out_frame_done = done_reg;

endmodule

// ===== src/pwm_frame_encoder_crc16_top.sv =====
// ----------------------------------------------------------------------------
// pwm_frame_encoder_crc16_top
// Pulse-width downlink frame encoder with reflected CRC-16 and end/recharge
// segments.
// ----------------------------------------------------------------------------
//  channel  dir  tdata / fields                          tuser         tlast
//  s_*      in   [7:0] data_byte, [15:8] recharge_time    first_of_frame last_of_frame
//  m_*      out  [0] drive_on, [18:1] duration_us        frame_done    end_of_run
//  cfg_*    in   cfg_addr register index, cfg_wdata value  -             -
//
//  One segment per clock from the sequencer in the back part unless m_tready
//  stalls it; a byte gives 16 to 58 segments, plus a load from the queue.
//  The front takes a new word each cycle while the queue has room.
//  Reset clears frame state, the queue and the output valid flag; config
//  registers return to their defaults.
//  A stalled m_tready holds the output word; the sequencer waits on it.
// ----------------------------------------------------------------------------
module pwm_frame_encoder_crc16_top
    import pfe_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // data_byte, recharge_time
    input  logic              s_tuser,   // first_of_frame
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // drive_on, duration_us, zero pad
    output logic              m_tuser,   // frame_done
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    cfg_t             cfg_reg;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    cmd_t             q_wr;
    cmd_t             q_rd;
    logic             drive_on;
    logic [DUR_W-1:0] duration;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_time        <= OFF_RST;
            cfg_reg.on_time_zero    <= ON_ZERO_RST;
            cfg_reg.on_time_one     <= ON_ONE_RST;
            cfg_reg.start_high_time <= START_HI_RST;
            cfg_reg.end_high_time   <= END_HI_RST;
            cfg_reg.crc_enable      <= 1'b1;
            cfg_reg.crc_seed        <= CRC_SEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_OFF_TIME:   cfg_reg.off_time        <= cfg_wdata[TIME_W-1:0];
                CFG_ON_ZERO:    cfg_reg.on_time_zero    <= cfg_wdata[TIME_W-1:0];
                CFG_ON_ONE:     cfg_reg.on_time_one     <= cfg_wdata[TIME_W-1:0];
                CFG_START_HIGH: cfg_reg.start_high_time <= cfg_wdata[TIME_W-1:0];
                CFG_END_HIGH:   cfg_reg.end_high_time   <= cfg_wdata[TIME_W-1:0];
                CFG_CRC_ENABLE: cfg_reg.crc_enable      <= cfg_wdata[0];
                CFG_CRC_SEED:   cfg_reg.crc_seed        <= cfg_wdata[CRC_W-1:0];
                default:        ;
            endcase
        end
    end

    pfe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_data     (s_tdata[7:0]),
        .in_first    (s_tuser),
        .in_last     (s_tlast),
        .in_recharge (s_tdata[15:8]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_wr)
    );

    pfe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_cmd    (q_wr),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_cmd    (q_rd)
    );

    pfe_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_cmd          (q_rd),
        .q_pop          (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_drive_on   (drive_on),
        .out_duration   (duration),
        .out_end_of_run (m_tlast),
        .out_frame_done (m_tuser)
    );

    assign m_tdata = {5'd0, duration, drive_on};

endmodule

// ===== src/pfe_checker.sv =====
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
module pfe_checker
    import pfe_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // final off segment closes the run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_done without end_of_run");

    // final off segment is level off with zero hold
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[18:0] == 19'd0))
        else $error("frame_done segment not off/zero");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

endmodule

bind pwm_frame_encoder_crc16_top pfe_checker u_pfe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-width frame encoder. A short table of
// directed words (register extremes, frame restarts, bytes sent with no frame
// open) is followed by random frames and noise under several register
// settings. Every output segment is compared with a local segment predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import pfe_pkg::*;

    localparam int  CYCLE_LIMIT  = 2_000_000;
    localparam int  SETTLE_WAIT  = 64;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  RAND_WORDS   = 400;
    localparam int  PHASE_WORDS  = 50;
    localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CFG_AW-1:0] addr;
        logic [CFG_DW-1:0] val;
        logic [7:0]       data;
        logic             first;
        logic             last;
        logic [7:0]       recharge;
        logic [7:0]       n_segs;     // 0: not typed
        logic             rch_known;
        logic [DUR_W-1:0] rch_us;
    } stim_row_t;

    typedef struct packed {
        logic             drive;
        logic [DUR_W-1:0] dur;
        logic             eor;
        logic             done;
    } seg_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    // typed expectations travel with the word on the input side
    logic [7:0]       cur_n_segs = '0;
    logic             cur_rch_known = 1'b0;
    logic [DUR_W-1:0] cur_rch_us = '0;

    pwm_frame_encoder_crc16_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    logic [TIME_W-1:0] reg_off     = OFF_RST;
    logic [TIME_W-1:0] reg_zero    = ON_ZERO_RST;
    logic [TIME_W-1:0] reg_one     = ON_ONE_RST;
    logic [TIME_W-1:0] reg_start   = START_HI_RST;
    logic [TIME_W-1:0] reg_end     = END_HI_RST;
    logic              reg_crc_en  = 1'b1;
    logic [CRC_W-1:0]  reg_seed    = CRC_SEED_RST;

    logic [CRC_W-1:0]  crc_acc     = CRC_SEED_RST;
    logic              in_frame    = 1'b0;

    seg_t expected_segs[$];
    seg_t held_seg;
    logic held_valid;
    int   seg_cnt;

    int   err_count   = 0;
    int   words_in    = 0;
    int   segs_seen   = 0;
    int   frames_seen = 0;
    int   cyc         = 0;

    bit   src_idle = 1'b1;
    bit   snk_idle = 1'b1;
    bit   hold_req = 1'b0;

    task automatic flag_error(input string what);
        err_count++;
        $display("tb_top: mismatch at cycle %0d: %s", cyc, what);
    endtask

    function automatic void apply_reg_write(input logic [CFG_AW-1:0] a,
                                            input logic [CFG_DW-1:0] v);
        case (a)
            CFG_OFF_TIME:   reg_off    = v[TIME_W-1:0];
            CFG_ON_ZERO:    reg_zero   = v[TIME_W-1:0];
            CFG_ON_ONE:     reg_one    = v[TIME_W-1:0];
            CFG_START_HIGH: reg_start  = v[TIME_W-1:0];
            CFG_END_HIGH:   reg_end    = v[TIME_W-1:0];
            CFG_CRC_ENABLE: reg_crc_en = v[0];
            CFG_CRC_SEED:   reg_seed   = v[CRC_W-1:0];
            default: ;
        endcase
    endfunction

    // last segment is held back so that end_of_run can be set on it
    function automatic void queue_seg(input logic lvl, input logic [DUR_W-1:0] dur,
                                      input logic done);
        if (held_valid)
            expected_segs.push_back(held_seg);
        held_seg   = {lvl, dur, 1'b0, done};
        held_valid = 1'b1;
        seg_cnt++;
    endfunction

    function automatic logic [DUR_W-1:0] bit_phase(input logic [TIME_W-1:0] v);
        if (v == '0)
            return '0;
        return {8'd0, v} - 1'b1;
    endfunction

    function automatic void queue_bits(input logic [15:0] v, input int nbits);
        for (int i = 0; i < nbits; i++) begin
            queue_seg(1'b0, bit_phase(reg_off), 1'b0);
            queue_seg(1'b1, bit_phase(v[i] ? reg_one : reg_zero), 1'b0);
        end
    endfunction

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c_in,
                                                 input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = c_in ^ {8'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic int predict_segments(input logic [7:0] d, input logic first,
                                            input logic last, input logic [7:0] rch);
        seg_cnt    = 0;
        held_valid = 1'b0;
        // a byte with no frame open opens one just like a first byte
        if (first || !in_frame) begin
            crc_acc  = reg_seed;
            in_frame = 1'b1;
            queue_seg(1'b0, {8'd0, reg_off},   1'b0);
            queue_seg(1'b1, {8'd0, reg_start}, 1'b0);
            queue_seg(1'b0, {8'd0, reg_off},   1'b0);
            queue_seg(1'b1, {8'd0, reg_zero},  1'b0);
            queue_seg(1'b0, {8'd0, reg_off},   1'b0);
            queue_seg(1'b1, {8'd0, reg_one},   1'b0);
        end
        queue_bits({8'd0, d}, 8);
        crc_acc = crc_step(crc_acc, d);
        if (last) begin
            if (reg_crc_en)
                queue_bits(crc_acc, 16);
            queue_seg(1'b0, {8'd0, reg_off}, 1'b0);
            queue_seg(1'b1, {8'd0, reg_end}, 1'b0);
            queue_seg(1'b1, {10'd0, rch} * US_PER_MS, 1'b0);
            queue_seg(1'b0, '0, 1'b1);
            in_frame = 1'b0;
        end
        held_seg.eor = 1'b1;
        expected_segs.push_back(held_seg);
        return seg_cnt;
    endfunction

    // ---------------------------------------------------------------- monitors
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cyc);
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            apply_reg_write(cfg_addr, cfg_wdata);
    end

    always @(posedge clk)
    begin : input_mon
        int n;
        if (rst_n && s_tvalid && s_tready) begin
            words_in++;
            n = predict_segments(s_tdata[7:0], s_tuser, s_tlast, s_tdata[15:8]);
            if (cur_n_segs != 0 && n != cur_n_segs)
                flag_error($sformatf("byte %02h gives %0d segments, table says %0d",
                                     s_tdata[7:0], n, cur_n_segs));
            if (cur_rch_known && expected_segs[expected_segs.size()-2].dur != cur_rch_us)
                flag_error($sformatf("recharge of byte %02h not %0d us",
                                     s_tdata[7:0], cur_rch_us));
        end
    end

    always @(posedge clk)
    begin : output_mon
        seg_t got;
        seg_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[DUR_W:1], m_tlast, m_tuser};
            segs_seen++;
            if (got.done)
                frames_seen++;
            if (expected_segs.size() == 0) begin
                flag_error($sformatf("unexpected word lvl %0d dur %0d", got.drive, got.dur));
            end
            else begin
                want = expected_segs.pop_front();
                if (got != want)
                    flag_error($sformatf(
                        "seg %0d: lvl %0d/%0d dur %0d/%0d last %0d/%0d done %0d/%0d",
                        segs_seen, got.drive, want.drive, got.dur, want.dur,
                        got.eor, want.eor, got.done, want.done));
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    initial
    begin : sink
        int w;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            w = snk_idle ? $urandom_range(0, 12) : 0;
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- sender
    stim_row_t stim_rows[$];
    bit        in_cfg = 1'b0;
    int        phases = 0;

    task automatic add_word(input logic [7:0] d, input logic f, input logic l,
                            input logic [7:0] r, input int n, input int rch);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_WORD;
        row.data      = d;
        row.first     = f;
        row.last      = l;
        row.recharge  = r;
        row.n_segs    = 8'(n);
        row.rch_known = (rch >= 0);
        row.rch_us    = (rch >= 0) ? DUR_W'(rch) : '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] v);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_CFG;
        row.addr = a;
        row.val  = v;
        stim_rows.push_back(row);
    endtask

    task automatic set_timings(input logic [CFG_DW-1:0] v);
        add_reg(CFG_OFF_TIME, v);
        add_reg(CFG_ON_ZERO, v);
        add_reg(CFG_ON_ONE, v);
        add_reg(CFG_START_HIGH, v);
        add_reg(CFG_END_HIGH, v);
    endtask

    task automatic send_word(input logic [7:0] d, input logic f, input logic l,
                             input logic [7:0] r, input logic [7:0] n,
                             input logic rk, input logic [DUR_W-1:0] rus);
        int g;
        g = src_idle ? $urandom_range(0, 12) : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= {r, d};
        s_tuser       <= f;
        s_tlast       <= l;
        cur_n_segs    <= n;
        cur_rch_known <= rk;
        cur_rch_us    <= rus;
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
    endtask

    // block drained: nothing pending, then a margin for the sequencer
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_segs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    function automatic logic [CFG_DW-1:0] pick_time(input int mode);
        int k;
        if (mode == 0)
            return 16'd1;
        if (mode == 1)
            return 16'd1023;
        k = $urandom_range(0, 7);
        if (k == 0)
            return 16'd0;
        if (k == 1)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(1, 1023));
    endfunction

    initial
    begin : stim
        int        rand_words;
        int        phase_words;
        int        flen;
        int        mode;
        logic [15:0] en_val;
        stim_row_t row;

        // defaults after reset
        add_word(8'h00, 1'b1, 1'b1, 8'd0,   58, 0);
        add_word(8'hFF, 1'b1, 1'b1, 8'd255, 58, 255000);
        add_word(8'hA5, 1'b0, 1'b0, 8'd9,   22, -1);      // no frame open
        add_word(8'h5A, 1'b0, 1'b0, 8'd0,   16, -1);
        add_word(8'h3C, 1'b1, 1'b0, 8'd0,   22, -1);      // restart an open frame
        add_word(8'h01, 1'b0, 1'b1, 8'd1,   52, 1000);
        add_word(8'h80, 1'b0, 1'b1, 8'd128, 58, 128000);
        // zero timings, crc off
        set_timings(16'd0);
        add_reg(CFG_CRC_ENABLE, 16'd0);
        add_reg(CFG_CRC_SEED, 16'h0000);
        add_reg(CFG_UNUSED, 16'hFFFF);
        add_word(8'h00, 1'b1, 1'b1, 8'd0,   26, 0);
        add_word(8'hFF, 1'b0, 1'b0, 8'd77,  22, -1);
        add_word(8'h55, 1'b0, 1'b1, 8'd7,   20, 7000);
        // top of range
        set_timings(16'd1023);
        add_reg(CFG_CRC_ENABLE, 16'd1);
        add_reg(CFG_CRC_SEED, 16'hFFFF);
        add_word(8'hFF, 1'b1, 1'b1, 8'd255, 58, 255000);
        add_word(8'hAA, 1'b1, 1'b0, 8'd0,   22, -1);
        add_word(8'h55, 1'b0, 1'b1, 8'd3,   52, 3000);
        // upper bits of the write data are dropped
        set_timings(16'hFC01);
        add_reg(CFG_CRC_ENABLE, 16'hFFFE);
        add_reg(CFG_CRC_SEED, 16'h8001);
        add_word(8'h12, 1'b1, 1'b1, 8'd200, 26, 200000);
        add_word(8'hC3, 1'b1, 1'b0, 8'd0,   22, -1);
        add_word(8'h3C, 1'b0, 1'b1, 8'd1,   20, 1000);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG) begin
                if (!in_cfg) begin
                    settle();
                    in_cfg = 1'b1;
                end
                cfg_write(row.addr, row.val);
            end
            else begin
                if (in_cfg) begin
                    cfg_we <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_word(row.data, row.first, row.last, row.recharge,
                          row.n_segs, row.rch_known, row.rch_us);
            end
        end
        if (in_cfg)
            cfg_we <= 1'b0;

        rand_words = 0;
        while (rand_words < RAND_WORDS) begin
            settle();
            mode = (phases < 2) ? phases : 2;
            cfg_write(CFG_OFF_TIME,   pick_time(mode));
            cfg_write(CFG_ON_ZERO,    pick_time(mode));
            cfg_write(CFG_ON_ONE,     pick_time(mode));
            cfg_write(CFG_START_HIGH, pick_time(mode));
            cfg_write(CFG_END_HIGH,   pick_time(mode));
            en_val = 16'($urandom_range(0, 65535));
            en_val[0] = (mode < 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
            cfg_write(CFG_CRC_ENABLE, en_val);
            cfg_write(CFG_CRC_SEED, (mode == 0) ? 16'h0000 :
                                    (mode == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
            cfg_write(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            cfg_we <= 1'b0;

            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            if (phases == 2) begin
                // receiver stops for a long stretch while words keep coming
                src_idle = 1'b0;
                hold_req = 1'b1;
            end

            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                if ($urandom_range(0, 4) != 0) begin
                    flen = $urandom_range(1, 6);
                    for (int j = 0; j < flen; j++)
                        send_word(8'($urandom_range(0, 255)), j == 0, j == flen - 1,
                                  8'($urandom_range(0, 255)), 8'd0, 1'b0, '0);
                    phase_words += flen;
                end
                else begin
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              8'd0, 1'b0, '0);
                    phase_words++;
                end
            end
            rand_words += phase_words;
            phases++;
        end

        settle();
        $display("tb_top: %0d words in, %0d segments checked, %0d frames closed",
                 words_in, segs_seen, frames_seen);
        $display("tb_top: %0d random register settings after the directed table", phases);
        if (err_count == 0 && expected_segs.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
